[hdl/pid_position_tracker_core_defines.svh]
// Assertion macros shared by the position tracker RTL.
// Define ASSERT_OFF to drop every check.
`ifndef PID_POSITION_TRACKER_CORE_DEFINES_SVH
`define PID_POSITION_TRACKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define PPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hdl/ppt_pkg.sv]
package ppt_pkg;

    localparam int PPT_TABLE_DEPTH = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MODE  = 3'd5;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_LOAD    = 2'd1,
        REQ_RESTART = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_HOLD  = 2'd1,
        MODE_TRACK = 2'd2
    } t_mode;

    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] int_gain;
        logic signed [31:0] deriv_gain;
        logic signed [31:0] hold_target;
        logic [8:0]         track_len;
        logic [1:0]         start_mode;
    } t_cfg;

    // request leaving the sequencer, registered on accept
    typedef struct packed {
        logic               vld;       // tick that yields a result
        logic               rst;       // restart
        logic               trk;       // target comes from the trajectory memory
        logic [7:0]         slot;
        logic               mode_now;
        logic               done;
        logic signed [31:0] meas;
    } t_s1;

    // per-tick tag carried down the arithmetic pipe
    typedef struct packed {
        logic signed [31:0] err;
        logic [7:0]         slot;
        logic               mode_now;
        logic               done;
    } t_tag;

    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [31:0] err;
        logic [7:0]         slot;
        logic               mode_now;
        logic               done;
    } t_res;

endpackage

[hdl/ppt_ram.sv]
module ppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ppt_seq.sv]
`include "pid_position_tracker_core_defines.svh"

module ppt_seq #(
    parameter int TABLE_DEPTH = ppt_pkg::PPT_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  logic [1:0]         i_req,
    input  logic signed [31:0] i_meas,
    input  logic [7:0]         i_idx,
    input  logic signed [31:0] i_val,
    input  ppt_pkg::t_cfg      i_cfg,
    output ppt_pkg::t_s1       o_s1,
    output logic signed [31:0] o_rdata
);
    import ppt_pkg::*;

    localparam int PW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (LW > 9) ? LW : 9;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_mode         r_mode, n_mode;
    logic [PW-1:0] r_step, n_step;
    t_s1           r_s1, n_s1;

    logic          accept;
    logic          active;
    logic          done;
    logic          ram_we;
    logic          ram_re;
    logic [CW-1:0] tl_ext;
    logic [CW-1:0] len;
    logic [CW-1:0] lm1;
    logic [CW-1:0] step_ext;
    logic [CW-1:0] slot;
    logic [CW-1:0] idx_ext;
    logic [31:0]   rdata;

    assign accept = i_valid & i_adv;
    assign active = (r_mode == MODE_HOLD) || (r_mode == MODE_TRACK);

    // effective length clamped to [1, depth]; slot clamped if the length shrank
    always_comb begin
        tl_ext   = CW'(i_cfg.track_len);
        if (tl_ext == '0) begin
            len = CW'(1);
        end else if (tl_ext > DEPTH_C) begin
            len = DEPTH_C;
        end else begin
            len = tl_ext;
        end
        lm1      = len - CW'(1);
        step_ext = CW'(r_step);
        if ((r_mode == MODE_TRACK) && (step_ext > lm1)) begin
            slot = lm1;
        end else begin
            slot = step_ext;
        end
        done     = (r_mode == MODE_TRACK) && (slot == lm1);
    end

    // next mode and step pointer
    always_comb begin
        n_mode = r_mode;
        n_step = r_step;
        if (accept) begin
            case (i_req)
                REQ_TICK: begin
                    if (r_mode == MODE_TRACK) begin
                        if (done) begin
                            n_mode = MODE_HOLD;
                            n_step = slot[PW-1:0];
                        end else begin
                            n_step = slot[PW-1:0] + PW'(1);
                        end
                    end
                end
                REQ_RESTART: begin
                    n_step = '0;
                    case (i_cfg.start_mode)
                        MODE_HOLD:  n_mode = MODE_HOLD;
                        MODE_TRACK: n_mode = MODE_TRACK;
                        default:    n_mode = MODE_OFF;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // stage outputs and memory port
    always_comb begin
        idx_ext       = CW'(i_idx);
        ram_we        = accept && (i_req == REQ_LOAD) && (idx_ext < DEPTH_C);
        ram_re        = accept && (i_req == REQ_TICK) && (r_mode == MODE_TRACK);
        n_s1.vld      = accept && (i_req == REQ_TICK) && active;
        n_s1.rst      = accept && (i_req == REQ_RESTART);
        n_s1.trk      = (r_mode == MODE_TRACK);
        n_s1.slot     = slot[7:0];
        n_s1.mode_now = (n_mode == MODE_TRACK);
        n_s1.done     = done;
        n_s1.meas     = i_meas;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OFF;
            r_step <= '0;
            r_s1   <= '0;
        end else begin
            r_mode <= n_mode;
            r_step <= n_step;
            if (i_adv) begin
                r_s1 <= n_s1;
            end
        end
    end

    ppt_ram #(
        .WIDTH(32),
        .DEPTH(TABLE_DEPTH)
    ) u_traj (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(idx_ext[PW-1:0]),
        .i_wdata(i_val),
        .i_re   (ram_re),
        .i_raddr(slot[PW-1:0]),
        .o_rdata(rdata)
    );

    assign o_s1    = r_s1;
    assign o_rdata = rdata;

    `PPT_ASSERT(a_ram_port, i_clk, i_rst_n, !(ram_we && ram_re), "memory read and write together")
    `PPT_ASSERT(a_done_hold, i_clk, i_rst_n, (r_s1.vld && r_s1.done) |-> !r_s1.mode_now, "done tick still tracking")
    `PPT_ASSERT(a_restart, i_clk, i_rst_n, (accept && i_req == REQ_RESTART) |=> (r_step == '0), "restart kept step")

endmodule

[hdl/ppt_loop.sv]
module ppt_loop (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  ppt_pkg::t_s1       i_s1,
    input  logic signed [31:0] i_rdata,
    input  ppt_pkg::t_cfg      i_cfg,
    input  logic               i_hold_wr,
    input  logic signed [31:0] i_hold_val,
    output logic               o_vld,
    output ppt_pkg::t_res      o_res
);
    import ppt_pkg::*;

    function automatic logic signed [31:0] sat_33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [39:0] sat_41(input logic signed [40:0] v);
        logic signed [39:0] r;
        if (v[40] != v[39]) begin
            r = v[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        end else begin
            r = v[39:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_59(input logic signed [58:0] v);
        logic signed [31:0] r;
        if (v[58:31] == {28{v[58]}}) begin
            r = v[31:0];
        end else begin
            r = v[58] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    // loop state
    logic signed [31:0] r_held;
    logic signed [39:0] r_esum;
    logic signed [31:0] r_last;

    // pipeline registers
    logic               r_v2, r_r2, r_v3, r_v4, r_v5, r_v6, r_v7;
    t_tag               r_c2, r_c3, r_c4, r_c5, r_c6, r_c7;
    logic signed [39:0] r_esum3, r_esum4;
    logic signed [32:0] r_diff3;
    logic signed [63:0] r_p1_4, r_p1_5;
    logic signed [40:0] r_dd4;
    logic signed [55:0] r_m2h;
    logic signed [48:0] r_m2l;
    logic signed [56:0] r_m3h;
    logic signed [48:0] r_m3l;
    logic signed [57:0] r_hi6;
    logic signed [65:0] r_lo6;
    logic signed [58:0] r_drv7;

    logic signed [31:0] target;
    logic signed [32:0] dif1;
    t_tag               c1;
    logic signed [40:0] sum2;
    logic signed [32:0] diff2;
    logic signed [40:0] d41;
    logic signed [40:0] dd3;
    logic signed [63:0] p1;
    logic signed [55:0] m2h;
    logic signed [48:0] m2l;
    logic signed [56:0] m3h;
    logic signed [48:0] m3l;
    logic signed [57:0] hi5;
    logic signed [65:0] lo5;
    logic signed [58:0] drv6;

    // S1: target and error
    always_comb begin
        target      = i_s1.trk ? i_rdata : r_held;
        dif1        = {i_s1.meas[31], i_s1.meas} - {target[31], target};
        c1.err      = sat_33(dif1);
        c1.slot     = i_s1.slot;
        c1.mode_now = i_s1.mode_now;
        c1.done     = i_s1.done;
    end

    // S2: integrator and difference, S3: x200 and P term
    always_comb begin
        sum2  = {r_esum[39], r_esum} + {{9{r_c2.err[31]}}, r_c2.err};
        diff2 = {r_c2.err[31], r_c2.err} - {r_last[31], r_last};
        d41   = {{8{r_diff3[32]}}, r_diff3};
        dd3   = (d41 <<< 7) + (d41 <<< 6) + (d41 <<< 3);
        p1    = r_c3.err * i_cfg.prop_gain;
    end

    // S4: split products, S5: partial sums, S6: drive before clamp
    always_comb begin
        m2h  = i_cfg.int_gain * $signed(r_esum4[39:16]);
        m2l  = i_cfg.int_gain * $signed({1'b0, r_esum4[15:0]});
        m3h  = i_cfg.deriv_gain * $signed(r_dd4[40:16]);
        m3l  = i_cfg.deriv_gain * $signed({1'b0, r_dd4[15:0]});
        hi5  = {{2{r_m2h[55]}}, r_m2h} + {r_m3h[56], r_m3h};
        lo5  = {{2{r_p1_5[63]}}, r_p1_5} + {{17{r_m2l[48]}}, r_m2l}
             + {{17{r_m3l[48]}}, r_m3l};
        // floor(hi*2^16 + lo) / 2^16 = hi + floor(lo / 2^16)
        drv6 = {r_hi6[57], r_hi6} + 59'(r_lo6 >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_esum <= '0;
            r_last <= '0;
            r_v2   <= 1'b0;
            r_r2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
        end else begin
            // hold target write lands in the live target at once
            if (i_hold_wr) begin
                r_held <= i_hold_val;
            end else if (i_adv && i_s1.vld && i_s1.trk) begin
                r_held <= i_rdata;
            end else if (i_adv && i_s1.rst) begin
                r_held <= i_cfg.hold_target;
            end
            if (i_adv) begin
                if (r_v2) begin
                    r_esum <= sat_41(sum2);
                    r_last <= r_c2.err;
                end else if (r_r2) begin
                    r_esum <= '0;
                    r_last <= '0;
                end
                r_v2 <= i_s1.vld;
                r_r2 <= i_s1.rst;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_v5 <= r_v4;
                r_v6 <= r_v5;
                r_v7 <= r_v6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c2    <= c1;
            r_c3    <= r_c2;
            r_esum3 <= r_esum;
            r_diff3 <= diff2;
            r_c4    <= r_c3;
            r_esum4 <= r_esum3;
            r_dd4   <= dd3;
            r_p1_4  <= p1;
            r_c5    <= r_c4;
            r_p1_5  <= r_p1_4;
            r_m2h   <= m2h;
            r_m2l   <= m2l;
            r_m3h   <= m3h;
            r_m3l   <= m3l;
            r_c6    <= r_c5;
            r_hi6   <= hi5;
            r_lo6   <= lo5;
            r_c7    <= r_c6;
            r_drv7  <= drv6;
        end
    end

    always_comb begin
        o_vld          = r_v7;
        o_res.drive    = sat_59(r_drv7);
        o_res.err      = r_c7.err;
        o_res.slot     = r_c7.slot;
        o_res.mode_now = r_c7.mode_now;
        o_res.done     = r_c7.done;
    end

endmodule

[hdl/ppt_outq.sv]
`include "pid_position_tracker_core_defines.svh"

module ppt_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ppt_pkg::t_res i_res,
    input  logic          i_ready,
    output logic          o_valid,
    output ppt_pkg::t_res o_res,
    output logic          o_room
);
    import ppt_pkg::*;

    t_res       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid & i_ready;
    assign o_room  = (r_cnt != 2'd2) | pop;
    assign o_res   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
    end

    `PPT_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "result queue count out of range")
    `PPT_ASSERT(a_no_overrun, i_clk, i_rst_n, (r_cnt == 2'd2 && !pop) |-> !i_push, "push into full queue")
    `PPT_ASSERT(a_push_shows, i_clk, i_rst_n, (r_cnt == 2'd0 && i_push) |=> o_valid, "pushed result not shown")

endmodule

[hdl/pid_position_tracker_core.sv]
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tuser req_type; tdata count, slot, value
// m_axis    out  m_axis_tvalid/tready        tdata drive, error, step; tuser mode; tlast done
// cfg       in   i_cfg_we (no wait)          i_cfg_index, i_cfg_wdata
//
// One request per cycle is taken while the result queue has room; the
// trajectory memory read and the error accumulator update do not slow it.
// A tick's result passes the sequencer register, the multiply / add pipe and the result queue.
// Synchronous active-low reset clears mode, step, loop state and config;
// the trajectory memory is not cleared.
// A two-entry result queue takes up output stalls; the pipe freezes only
// when both entries are full and the sink is not taking one.
module pid_position_tracker_core #(
    parameter int TABLE_DEPTH = ppt_pkg::PPT_TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_wdata,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // measured_count[31:0], entry_index[39:32], entry_value[71:40]
    input  logic [ppt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]                        s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // drive_command[31:0], error_now[63:32], step_index[71:64]
    output logic [ppt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // mode_now[0]
    output logic [0:0]                        m_axis_tuser,
    // track_done
    output logic                              m_axis_tlast
);
    import ppt_pkg::*;

    t_cfg  r_cfg;
    t_s1   s1;
    t_res  loop_res;
    t_res  q_res;
    logic  adv;
    logic  loop_vld;
    logic  hold_wr;
    logic signed [31:0] rdata;

    // configuration registers; writes must come only while the block is idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= '0;
            r_cfg.int_gain    <= '0;
            r_cfg.deriv_gain  <= '0;
            r_cfg.hold_target <= '0;
            r_cfg.track_len   <= 9'd1;
            r_cfg.start_mode  <= MODE_OFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg_wdata;
                CFG_INT_GAIN:    r_cfg.int_gain    <= i_cfg_wdata;
                CFG_DERIV_GAIN:  r_cfg.deriv_gain  <= i_cfg_wdata;
                CFG_HOLD_TARGET: r_cfg.hold_target <= i_cfg_wdata;
                CFG_TRACK_LEN:   r_cfg.track_len   <= i_cfg_wdata[8:0];
                CFG_START_MODE:  r_cfg.start_mode  <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // hold target write also lands in the live target
    assign hold_wr       = i_cfg_we && (i_cfg_index == CFG_HOLD_TARGET);
    assign s_axis_tready = adv;

    ppt_seq #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_valid(s_axis_tvalid),
        .i_req  (s_axis_tuser),
        .i_meas (s_axis_tdata[31:0]),
        .i_idx  (s_axis_tdata[39:32]),
        .i_val  (s_axis_tdata[71:40]),
        .i_cfg  (r_cfg),
        .o_s1   (s1),
        .o_rdata(rdata)
    );

    ppt_loop u_loop (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_s1      (s1),
        .i_rdata   (rdata),
        .i_cfg     (r_cfg),
        .i_hold_wr (hold_wr),
        .i_hold_val(i_cfg_wdata),
        .o_vld     (loop_vld),
        .o_res     (loop_res)
    );

    ppt_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (loop_vld & adv),
        .i_res  (loop_res),
        .i_ready(m_axis_tready),
        .o_valid(m_axis_tvalid),
        .o_res  (q_res),
        .o_room (adv)
    );

    assign m_axis_tdata    = {q_res.slot, q_res.err, q_res.drive};
    assign m_axis_tuser[0] = q_res.mode_now;
    assign m_axis_tlast    = q_res.done;

endmodule

[bench/tb.sv]
import ppt_pkg::*;

// Predicts the drive stream of the position loop and checks it against the
// block's results, oldest first.
class drive_checker;
    // register copies
    logic signed [31:0] prop_gain, int_gain, deriv_gain, hold_target;
    logic [8:0]         track_len;
    logic [1:0]         start_mode;
    // loop state
    t_mode              loop_mode;
    logic [7:0]         step_ptr;
    logic signed [31:0] held_target, last_error;
    logic signed [39:0] error_sum;
    logic signed [31:0] trajectory [PPT_TABLE_DEPTH];

    t_res pending_drives[$];
    int   errors, results_seen, runs_finished, sum_clamps;

    function new();
        prop_gain   = '0;
        int_gain    = '0;
        deriv_gain  = '0;
        hold_target = '0;
        track_len   = 9'd1;
        start_mode  = 2'd0;
        loop_mode   = MODE_OFF;
        step_ptr    = '0;
        held_target = '0;
        last_error  = '0;
        error_sum   = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            CFG_PROP_GAIN:   prop_gain = data;
            CFG_INT_GAIN:    int_gain = data;
            CFG_DERIV_GAIN:  deriv_gain = data;
            CFG_HOLD_TARGET: begin
                hold_target = data;
                held_target = data;
            end
            CFG_TRACK_LEN:   track_len = data[8:0];
            CFG_START_MODE:  start_mode = data[1:0];
            default: ;
        endcase
    endfunction

    function void note_request(logic [1:0] req, logic signed [31:0] meas,
                               logic [7:0] idx, logic signed [31:0] val);
        logic [8:0]         len, len_m1;
        logic [7:0]         slot;
        logic               done;
        logic signed [32:0] raw_err;
        logic signed [31:0] err;
        logic signed [40:0] next_sum;
        logic signed [79:0] kp, ki, kd, e_w, s_w, d_w, total;
        t_res               r;
        done = 1'b0;
        case (req)
            REQ_LOAD: begin
                trajectory[idx] = val;
                return;
            end
            REQ_RESTART: begin
                error_sum   = '0;
                last_error  = '0;
                step_ptr    = '0;
                held_target = hold_target;
                loop_mode   = (start_mode == 2'd3) ? MODE_OFF : t_mode'(start_mode);
                return;
            end
            REQ_TICK: ;
            default: return;    // unused request type
        endcase
        if (loop_mode != MODE_HOLD && loop_mode != MODE_TRACK)
            return;

        if (loop_mode == MODE_TRACK) begin
            // zero counts as one entry, anything past the table as the full table
            len = (track_len == 9'd0) ? 9'd1 :
                  (track_len > 9'd256) ? 9'd256 : track_len;
            len_m1 = len - 9'd1;
            // a shrunken length while tracking clamps to the last valid entry
            slot = ({1'b0, step_ptr} > len_m1) ? len_m1[7:0] : step_ptr;
            held_target = trajectory[slot];
            if ({1'b0, slot} + 9'd1 >= len) begin
                step_ptr  = slot;
                loop_mode = MODE_HOLD;
                done      = 1'b1;
                runs_finished++;
            end else begin
                step_ptr = slot + 8'd1;
            end
        end else begin
            slot = step_ptr;
        end

        raw_err = 33'(meas) - 33'(held_target);
        if (raw_err[32] != raw_err[31])
            err = raw_err[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            err = raw_err[31:0];

        // exact Q16.16 sum, then floor via arithmetic shift
        kp  = 80'(prop_gain);
        ki  = 80'(int_gain);
        kd  = 80'(deriv_gain);
        e_w = 80'(err);
        s_w = 80'(error_sum);
        d_w = 80'(err);
        d_w = (d_w - 80'(last_error)) * 80'sd200;
        total = (kp * e_w + ki * s_w + kd * d_w) >>> 16;

        r.drive    = (total > 80'sd2147483647) ? 32'sh7FFF_FFFF :
                     (total < -80'sd2147483648) ? 32'sh8000_0000 : total[31:0];
        r.err      = err;
        r.slot     = slot;
        r.mode_now = (loop_mode == MODE_TRACK);
        r.done     = done;
        pending_drives.push_back(r);

        next_sum = 41'(error_sum) + 41'(err);
        if (next_sum[40] != next_sum[39]) begin
            error_sum = next_sum[40] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
            sum_clamps++;
        end else begin
            error_sum = next_sum[39:0];
        end
        last_error = err;
    endfunction

    function void compare(string field, longint want, longint seen);
        if (want != seen) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
            errors++;
        end
    endfunction

    function void check_drive(t_res got);
        t_res want;
        results_seen++;
        if (pending_drives.size() == 0) begin
            $display("%0t: unexpected result, expected none, got drive %0d",
                     $time, $signed(got.drive));
            errors++;
            return;
        end
        want = pending_drives.pop_front();
        compare("drive_command", $signed(want.drive), $signed(got.drive));
        compare("error_now", $signed(want.err), $signed(got.err));
        compare("step_index", want.slot, got.slot);
        compare("mode_now", want.mode_now, got.mode_now);
        compare("track_done", want.done, got.done);
    endfunction
endclass

module tb;

    localparam logic [1:0]         REQ_UNUSED = 2'd3;    // type the block drops
    localparam logic signed [31:0] COUNT_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COUNT_MIN  = 32'sh8000_0000;
    localparam int                 SETTLE_CYCLES = 12;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [31:0]           i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // measured_count, entry_index, entry_value
    logic [1:0]            s_axis_tuser = '0;   // req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // drive_command, error_now, step_index
    logic [0:0]            m_axis_tuser;        // mode_now
    logic                  m_axis_tlast;        // track_done

    drive_checker board = new();

    int send_idle_pct = 0;      // chance of an idle cycle before each request
    int stall_pct = 0;          // chance of holding tready low on a cycle
    int requests_sent = 0;
    bit loaded [PPT_TABLE_DEPTH];   // trajectory slots written so far

    pid_position_tracker_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // result side: random stalls and the check of every accepted result
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.drive    = m_axis_tdata[31:0];
            got.err      = m_axis_tdata[63:32];
            got.slot     = m_axis_tdata[71:64];
            got.mode_now = m_axis_tuser[0];
            got.done     = m_axis_tlast;
            board.check_drive(got);
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // one request; returns at the edge that accepted it
    task automatic send_request(logic [1:0] req, logic [31:0] meas,
                                logic [31:0] slot_word, logic [31:0] val);
        logic [7:0] idx;
        idx = slot_word[7:0];
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, idx, meas};
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (req == REQ_LOAD)
            loaded[idx] = 1'b1;
        requests_sent++;
        board.note_request(req, meas, idx, val);
    endtask

    // stop sending until every predicted drive is back, then let the pipe empty
    task automatic wait_for_drives();
        s_axis_tvalid <= 1'b0;
        while (board.pending_drives.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic setup_loop(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                              logic [31:0] hold, logic [8:0] len, logic [1:0] mode);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INT_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_HOLD_TARGET, hold);
        write_reg(CFG_TRACK_LEN, {23'($urandom_range(127)), len});   // junk above the field
        write_reg(CFG_START_MODE, {30'd0, mode});
    endtask

    // make sure every slot a track run can read has been written
    task automatic fill_table(logic [8:0] len, int min_pct, bit redo_all);
        int eff;
        eff = (len == 0) ? 1 : (len > 256) ? 256 : len;
        for (int i = 0; i < eff; i++)
            if (redo_all || !loaded[i])
                send_request(REQ_LOAD, $urandom, i,
                             ($urandom_range(99) < min_pct) ? COUNT_MIN : $urandom);
    endtask

    function automatic logic [31:0] pick_count(logic [31:0] target);
        case ($urandom_range(9))
            0:       return COUNT_MAX;
            1:       return COUNT_MIN;
            2, 3, 4: return target + $urandom_range(2000) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(7))
            0:       return COUNT_MAX;
            1:       return COUNT_MIN;
            2:       return '0;
            3, 4, 5: return $urandom_range(32'h0006_0000) - 32'h0003_0000;   // +-3.0
            default: return $urandom;
        endcase
    endfunction

    // mostly ticks, with loads, restarts, dropped types and the odd full drain
    task automatic run_mix(int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_request(REQ_TICK, pick_count(board.held_target), $urandom, $urandom);
            else if (pick < 84)
                send_request(REQ_LOAD, $urandom, $urandom, pick_count(board.held_target));
            else if (pick < 94)
                send_request(REQ_RESTART, $urandom, $urandom, $urandom);
            else if (pick < 97)
                send_request(REQ_UNUSED, $urandom, $urandom, $urandom);
            else
                wait_for_drives();
        end
    endtask

    initial begin
        #(12 * 400000);
        $display("[pid_position_tracker_core] ERROR");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // loop is off after reset: a tick yields nothing, type 3 is dropped
        send_request(REQ_TICK, COUNT_MAX, $urandom, $urandom);
        send_request(REQ_UNUSED, $urandom, $urandom, $urandom);
        wait_for_drives();
        // hold at the lowest target: errors saturate high, derivative is huge
        setup_loop(32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, COUNT_MIN, 9'd3, MODE_HOLD);
        send_request(REQ_LOAD, $urandom, 32'd0, COUNT_MAX);
        send_request(REQ_LOAD, $urandom, 32'd1, COUNT_MIN);
        send_request(REQ_LOAD, $urandom, 32'd2, 32'd0);
        send_request(REQ_RESTART, $urandom, $urandom, $urandom);
        send_request(REQ_TICK, COUNT_MAX, $urandom, $urandom);
        send_request(REQ_TICK, COUNT_MIN, $urandom, $urandom);
        send_request(REQ_TICK, 32'hFFFF_FFFF, $urandom, $urandom);
        wait_for_drives();
        // extreme gains over a three-entry run: drive clamps both ways, run ends
        setup_loop(COUNT_MAX, COUNT_MIN, COUNT_MAX, COUNT_MAX, 9'd3, MODE_TRACK);
        send_request(REQ_RESTART, $urandom, $urandom, $urandom);
        send_request(REQ_TICK, COUNT_MIN, $urandom, $urandom);
        send_request(REQ_TICK, COUNT_MAX, $urandom, $urandom);
        send_request(REQ_TICK, 32'd0, $urandom, $urandom);
        send_request(REQ_TICK, 32'd5, $urandom, $urandom);
        wait_for_drives();
        // one-entry run finishes on its first tick
        write_reg(CFG_TRACK_LEN, 32'd1);
        send_request(REQ_RESTART, $urandom, $urandom, $urandom);
        send_request(REQ_TICK, 32'd0, $urandom, $urandom);
        send_request(REQ_TICK, COUNT_MAX, $urandom, $urandom);
        wait_for_drives();
        // start mode three restarts into off
        write_reg(CFG_START_MODE, 32'd3);
        send_request(REQ_RESTART, $urandom, $urandom, $urandom);
        send_request(REQ_TICK, 32'd0, $urandom, $urandom);
        wait_for_drives();

        // --- random, no idling: short runs ---
        setup_loop(pick_gain(), pick_gain(), pick_gain(), $urandom,
                   9'($urandom_range(2, 20)), MODE_TRACK);
        fill_table(board.track_len, 10, 1'b0);
        send_request(REQ_RESTART, $urandom, $urandom, $urandom);
        run_mix(30);
        wait_for_drives();

        // --- sender idle 60%: 32-entry run, far-off targets drive the integral
        // into its clamp ---
        send_idle_pct = 60;
        setup_loop(pick_gain(), pick_gain(), pick_gain(), $urandom, 9'd32, MODE_TRACK);
        fill_table(9'd32, 95, 1'b1);
        send_request(REQ_LOAD, $urandom, 32'd31, COUNT_MIN);
        send_request(REQ_RESTART, $urandom, $urandom, $urandom);
        repeat (280)
            send_request(REQ_TICK, ($urandom_range(99) < 95) ? COUNT_MAX : $urandom,
                         $urandom, $urandom);
        wait_for_drives();

        // --- receiver stalls 60%: length shrinks under a running trajectory ---
        send_idle_pct = 0;
        stall_pct = 60;
        setup_loop(pick_gain(), pick_gain(), pick_gain(), $urandom, 9'd40, MODE_TRACK);
        send_request(REQ_RESTART, $urandom, $urandom, $urandom);
        repeat (20)
            send_request(REQ_TICK, pick_count(board.held_target), $urandom, $urandom);
        wait_for_drives();
        write_reg(CFG_TRACK_LEN, 32'd5);
        send_request(REQ_TICK, pick_count(board.held_target), $urandom, $urandom);
        run_mix(30);
        wait_for_drives();

        // --- both sides 36%: out-of-range lengths and every start mode ---
        send_idle_pct = 36;
        stall_pct = 36;
        setup_loop(pick_gain(), pick_gain(), pick_gain(), $urandom, 9'd0, MODE_TRACK);
        send_request(REQ_RESTART, $urandom, $urandom, $urandom);
        run_mix(15);
        wait_for_drives();
        // a mix this short never reads past the first 32 slots
        setup_loop(pick_gain(), pick_gain(), pick_gain(), $urandom, 9'd511, MODE_TRACK);
        fill_table(9'd32, 0, 1'b0);
        send_request(REQ_RESTART, $urandom, $urandom, $urandom);
        run_mix(15);
        wait_for_drives();
        setup_loop(pick_gain(), pick_gain(), pick_gain(), $urandom,
                   9'($urandom_range(1, 300)), MODE_OFF);
        send_request(REQ_RESTART, $urandom, $urandom, $urandom);
        run_mix(10);
        wait_for_drives();
        write_reg(CFG_START_MODE, $urandom_range(1, 3));
        send_request(REQ_RESTART, $urandom, $urandom, $urandom);
        run_mix(15);
        wait_for_drives();

        $display("Sent %0d requests under four idle/stall mixes; checked %0d drive results,",
                 requests_sent, board.results_seen);
        $display("%0d finished trajectory runs, %0d integral clamps.",
                 board.runs_finished, board.sum_clamps);
        if (board.errors == 0)
            $display("[pid_position_tracker_core] OK");
        else
            $display("[pid_position_tracker_core] ERROR");
        $finish;
    end

endmodule
